// ===== rtl/core/amld_pkg.sv =====
// Shared types, constants and symbol table for the adaptive Morse light decoder.
// No dependencies; used by the interfaces, the decode logic and the top level.
package amld_pkg;

  localparam int RUN_WIDTH    = 16;
  localparam int SAMPLE_WIDTH = 10;
  localparam int MAX_ELEMENTS = 7;

  localparam int THRESH_WIDTH = 10;
  localparam int LEN_WIDTH    = 16;
  localparam int CMP_WIDTH    = (RUN_WIDTH > LEN_WIDTH) ? RUN_WIDTH : LEN_WIDTH;
  localparam int SCMP_WIDTH   = (SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH;
  localparam int PAT_WIDTH    = 7;
  localparam int PLEN_WIDTH   = 4;
  localparam int CODE_WIDTH   = 7;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int TABLE_SIZE   = 37;

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_DARK_THRESHOLD   = 3'd0,
    REG_DOT_LENGTH       = 3'd1,
    REG_DASH_LENGTH      = 3'd2,
    REG_SHORT_GAP_LENGTH = 3'd3,
    REG_LONG_GAP_LENGTH  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_WIDTH-1:0] dark_threshold;
    logic [LEN_WIDTH-1:0]    dot_length;
    logic [LEN_WIDTH-1:0]    dash_length;
    logic [LEN_WIDTH-1:0]    short_gap_length;
    logic [LEN_WIDTH-1:0]    long_gap_length;
  } cfg_t;

  typedef struct packed {
    logic                  previous_dark;
    logic                  have_previous;
    logic [RUN_WIDTH-1:0]  mark_run;
    logic [RUN_WIDTH-1:0]  gap_run;
    logic [PAT_WIDTH-1:0]  pattern_bits;
    logic [PLEN_WIDTH-1:0] pattern_length;
    logic                  mark_seen;
  } state_t;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] code;
    logic [PLEN_WIDTH-1:0] len;
    logic [PAT_WIDTH-1:0]  bits;
  } sym_t;

  typedef struct packed {
    logic                  found;
    logic [CODE_WIDTH-1:0] code;
  } match_t;

  // element i in bit i, 1 = dash
  localparam sym_t SYM_TABLE [TABLE_SIZE] = '{
    '{7'd32, 4'd7, 7'h00},
    '{7'd65, 4'd2, 7'h02}, '{7'd66, 4'd4, 7'h01}, '{7'd67, 4'd4, 7'h05},
    '{7'd68, 4'd3, 7'h01}, '{7'd69, 4'd1, 7'h00}, '{7'd70, 4'd4, 7'h04},
    '{7'd71, 4'd3, 7'h03}, '{7'd72, 4'd4, 7'h00}, '{7'd73, 4'd2, 7'h00},
    '{7'd74, 4'd4, 7'h0E}, '{7'd75, 4'd3, 7'h05}, '{7'd76, 4'd4, 7'h02},
    '{7'd77, 4'd2, 7'h03}, '{7'd78, 4'd2, 7'h01}, '{7'd79, 4'd3, 7'h07},
    '{7'd80, 4'd4, 7'h06}, '{7'd81, 4'd4, 7'h0B}, '{7'd82, 4'd3, 7'h02},
    '{7'd83, 4'd3, 7'h00}, '{7'd84, 4'd1, 7'h01}, '{7'd85, 4'd3, 7'h04},
    '{7'd86, 4'd4, 7'h08}, '{7'd87, 4'd3, 7'h06}, '{7'd88, 4'd4, 7'h09},
    '{7'd89, 4'd4, 7'h0D}, '{7'd90, 4'd4, 7'h03},
    '{7'd48, 4'd5, 7'h1F}, '{7'd49, 4'd5, 7'h1E}, '{7'd50, 4'd5, 7'h1C},
    '{7'd51, 4'd5, 7'h18}, '{7'd52, 4'd5, 7'h10}, '{7'd53, 4'd5, 7'h00},
    '{7'd54, 4'd5, 7'h01}, '{7'd55, 4'd5, 7'h03}, '{7'd56, 4'd5, 7'h07},
    '{7'd57, 4'd5, 7'h0F}
  };

  // Entries are unique, so an OR over all hits gives the single match.
  function automatic match_t sym_lookup(input logic [PLEN_WIDTH-1:0] len,
                                        input logic [PAT_WIDTH-1:0]  bits);
    match_t m;
    m = '0;
    if (len >= PLEN_WIDTH'(1) && len <= PLEN_WIDTH'(MAX_ELEMENTS)) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (SYM_TABLE[i].len == len && SYM_TABLE[i].bits == bits) begin
          m.found = 1'b1;
          m.code  = m.code | SYM_TABLE[i].code;
        end
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/amld_ifs.sv =====
// Valid/ready channel interfaces: sample input, character output, register writes.
// Depends on amld_pkg for field widths.
interface amld_in_if;
  import amld_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    end_of_message;
  modport source (output valid, sample, end_of_message, input ready);
  modport sink   (input valid, sample, end_of_message, output ready);
endinterface

interface amld_out_if;
  import amld_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CODE_WIDTH-1:0] char_code;
  modport source (output valid, char_code, input ready);
  modport sink   (input valid, char_code, output ready);
endinterface

interface amld_cfg_if;
  import amld_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/adaptive_morse_light_decoder.sv =====
// Top level of the adaptive Morse light decoder: channels, registers, pipeline.
// Depends on amld_pkg, amld_ifs and amld_decode.
//
// in_ch carries one light sample per beat, or an end-of-message beat that
// flushes the pending pattern and clears the decoder state. out_ch carries
// one ASCII character (space, A-Z, 0-9) per beat, only when a symbol ends on
// a long gap or at end of message and its pattern is in the table.
// cfg writes the threshold and the four calibrated lengths by index; it is
// always ready and is meant to be used while the block is idle.
//
// Throughput: one sample per cycle while out_ch is not stalled. An input beat
// lands in an input register; when that register advances, the decode step
// updates the state and loads the result register, from which a character is
// offered for the beat that ends its symbol.
// The input register advances whenever the result register is empty or being
// taken, so a stalled receiver holds one result and one sample, and the
// ready on in_ch drops until out_ch moves again.
// Reset (rst, synchronous) clears the decoder state, empties both registers
// and restores the register defaults: threshold 512, dot 1, dash 2,
// short gap 1, long gap 2.
module adaptive_morse_light_decoder (
  input  logic       clk,
  input  logic       rst,
  amld_in_if.sink    in_ch,
  amld_out_if.source out_ch,
  amld_cfg_if.sink   cfg
);
  import amld_pkg::*;

  cfg_t                    regs;
  state_t                  state, state_next;

  logic                    s1_valid;
  logic [SAMPLE_WIDTH-1:0] s1_sample;
  logic                    s1_eom;
  logic                    s1_advance;

  logic                    emit;
  logic [CODE_WIDTH-1:0]   code;
  logic                    out_valid;
  logic [CODE_WIDTH-1:0]   out_code;

  assign s1_advance = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;
  assign out_ch.valid = out_valid;
  assign out_ch.char_code = out_code;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dark_threshold   <= THRESH_WIDTH'(512);
      regs.dot_length       <= LEN_WIDTH'(1);
      regs.dash_length      <= LEN_WIDTH'(2);
      regs.short_gap_length <= LEN_WIDTH'(1);
      regs.long_gap_length  <= LEN_WIDTH'(2);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DARK_THRESHOLD:   regs.dark_threshold   <= cfg.data[THRESH_WIDTH-1:0];
        REG_DOT_LENGTH:       regs.dot_length       <= cfg.data[LEN_WIDTH-1:0];
        REG_DASH_LENGTH:      regs.dash_length      <= cfg.data[LEN_WIDTH-1:0];
        REG_SHORT_GAP_LENGTH: regs.short_gap_length <= cfg.data[LEN_WIDTH-1:0];
        REG_LONG_GAP_LENGTH:  regs.long_gap_length  <= cfg.data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample <= in_ch.sample;
      s1_eom    <= in_ch.end_of_message;
    end
  end

  amld_decode u_decode (
    .cfg            (regs),
    .state          (state),
    .sample         (s1_sample),
    .end_of_message (s1_eom),
    .state_next     (state_next),
    .emit           (emit),
    .char_code      (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      out_code <= code;
    end
  end

  a_pat_len_range: assert property (@(posedge clk) disable iff (rst)
    state.pattern_length <= PLEN_WIDTH'(MAX_ELEMENTS + 1))
    else $error("pattern length out of range");

  a_pat_needs_mark: assert property (@(posedge clk) disable iff (rst)
    !state.mark_seen |-> state.pattern_length == '0)
    else $error("pattern held with no mark seen");

  a_one_run: assert property (@(posedge clk) disable iff (rst)
    state.mark_run == '0 || state.gap_run == '0)
    else $error("mark and gap runs both active");

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_eom |=> state.pattern_length == '0 && !state.have_previous
      && !state.mark_seen)
    else $error("end of message did not clear state");

endmodule

// ===== rtl/core/amld_decode.sv =====
// Per-sample decode step: dark/light class, run counting, element append, flush.
// Depends on amld_pkg (state and config types, symbol lookup).
module amld_decode (
  input  amld_pkg::cfg_t                        cfg,
  input  amld_pkg::state_t                      state,
  input  logic [amld_pkg::SAMPLE_WIDTH-1:0]     sample,
  input  logic                                  end_of_message,
  output amld_pkg::state_t                      state_next,
  output logic                                  emit,
  output logic [amld_pkg::CODE_WIDTH-1:0]       char_code
);
  import amld_pkg::*;

  logic                  dark;
  logic [CMP_WIDTH-1:0]  mark_ext, gap_ext;
  logic [CMP_WIDTH-1:0]  d_dot, d_dash, d_short, d_long;
  logic                  is_dash, is_long;
  match_t                hit;

  function automatic logic [CMP_WIDTH-1:0] abs_diff(input logic [CMP_WIDTH-1:0] a,
                                                    input logic [CMP_WIDTH-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign dark     = SCMP_WIDTH'(sample) > SCMP_WIDTH'(cfg.dark_threshold);
  assign mark_ext = CMP_WIDTH'(state.mark_run);
  assign gap_ext  = CMP_WIDTH'(state.gap_run);
  assign d_dot    = abs_diff(CMP_WIDTH'(cfg.dot_length), mark_ext);
  assign d_dash   = abs_diff(CMP_WIDTH'(cfg.dash_length), mark_ext);
  assign d_short  = abs_diff(CMP_WIDTH'(cfg.short_gap_length), gap_ext);
  assign d_long   = abs_diff(CMP_WIDTH'(cfg.long_gap_length), gap_ext);
  assign is_dash  = !(d_dot < d_dash);
  assign is_long  = !(d_short < d_long);
  assign hit      = sym_lookup(state.pattern_length, state.pattern_bits);
  assign char_code = hit.code;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    if (end_of_message) begin
      emit       = hit.found;
      state_next = '0;
    end else begin
      if (!dark) begin
        if (state.have_previous && state.previous_dark) begin
          // dark-to-light edge: append the finished element
          if (state.pattern_length < PLEN_WIDTH'(MAX_ELEMENTS)) begin
            state_next.pattern_bits[state.pattern_length[2:0]] =
              state.pattern_bits[state.pattern_length[2:0]] | is_dash;
            state_next.pattern_length = state.pattern_length + PLEN_WIDTH'(1);
          end else begin
            state_next.pattern_length = PLEN_WIDTH'(MAX_ELEMENTS + 1);
          end
          state_next.mark_seen = 1'b1;
          state_next.mark_run  = '0;
          state_next.gap_run   = RUN_WIDTH'(1);
        end else if (state.gap_run != RUN_MAX) begin
          state_next.gap_run = state.gap_run + RUN_WIDTH'(1);
        end
      end else begin
        if (state.have_previous && !state.previous_dark) begin
          // light-to-dark edge: a long gap closes the symbol
          if (is_long && state.mark_seen) begin
            emit                      = hit.found;
            state_next.pattern_bits   = '0;
            state_next.pattern_length = '0;
          end
          state_next.gap_run  = '0;
          state_next.mark_run = RUN_WIDTH'(1);
        end else if (state.mark_run != RUN_MAX) begin
          state_next.mark_run = state.mark_run + RUN_WIDTH'(1);
        end
      end
      state_next.previous_dark = dark;
      state_next.have_previous = 1'b1;
    end
  end

endmodule

// ===== bench/tb_adaptive_morse_light_decoder.sv =====
`timescale 1ns / 1ps
// Testbench for adaptive_morse_light_decoder: sample streams in, decoded ASCII out.
// Depends on amld_pkg, amld_ifs and the decoder RTL; carries its own Morse decode model.
module tb_adaptive_morse_light_decoder;
  import amld_pkg::*;

  localparam int SETTLE_CYCLES = 4;   // input reg + decode step, with margin
  localparam int MAX_PRINTS = 100;

  logic clk;
  logic rst;

  amld_in_if  in_ch();
  amld_out_if out_ch();
  amld_cfg_if cfg();

  adaptive_morse_light_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // character followed by its elements, element 0 first
  string morse_tab [37] = '{
    " .......", "A.-", "B-...", "C-.-.", "D-..", "E.", "F..-.", "G--.", "H....",
    "I..", "J.---", "K-.-", "L.-..", "M--", "N-.", "O---", "P.--.", "Q--.-",
    "R.-.", "S...", "T-", "U..-", "V...-", "W.--", "X-..-", "Y-.--", "Z--..",
    "0-----", "1.----", "2..---", "3...--", "4....-", "5.....", "6-....",
    "7--...", "8---..", "9----."
  };

  // decoder model: registers
  logic [THRESH_WIDTH-1:0] thr_q;
  logic [LEN_WIDTH-1:0]    dot_q, dash_q, sgap_q, lgap_q;
  // decoder model: state
  logic                  was_dark, have_sample, any_mark;
  logic [RUN_WIDTH-1:0]  dark_run, light_run;
  logic [PAT_WIDTH-1:0]  sym_bits;
  logic [PLEN_WIDTH-1:0] sym_len;

  logic [CODE_WIDTH-1:0] pending_chars [$];
  logic [CODE_WIDTH-1:0] want_code;
  int beats_sent = 0;
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  task automatic report_err(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic int gap_between(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void split_entry(input string e, output int n, output logic [8:0] bits);
    n = e.len() - 1;
    bits = '0;
    for (int k = 1; k < e.len(); k++)
      if (e[k] == "-") bits[k-1] = 1'b1;
  endfunction

  function automatic bit find_char(input logic [PLEN_WIDTH-1:0] len,
                                   input logic [PAT_WIDTH-1:0] bits,
                                   output logic [CODE_WIDTH-1:0] code);
    int n;
    logic [8:0] b;
    code = '0;
    if (len == 0 || len > MAX_ELEMENTS) return 1'b0;
    foreach (morse_tab[i]) begin
      split_entry(morse_tab[i], n, b);
      if (n == len && b[PAT_WIDTH-1:0] == bits) begin
        code = CODE_WIDTH'(morse_tab[i][0]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic clear_decoder();
    was_dark = 1'b0;
    have_sample = 1'b0;
    any_mark = 1'b0;
    dark_run = '0;
    light_run = '0;
    sym_bits = '0;
    sym_len = '0;
  endtask

  task automatic flush_symbol();
    logic [CODE_WIDTH-1:0] c;
    if (find_char(sym_len, sym_bits, c)) begin
      pending_chars.push_back(c);
    end
    sym_bits = '0;
    sym_len = '0;
  endtask

  task automatic add_element(input bit dash);
    if (sym_len < MAX_ELEMENTS) begin
      if (dash) sym_bits[sym_len] = 1'b1;
      sym_len++;
    end else begin
      sym_len = PLEN_WIDTH'(MAX_ELEMENTS + 1);  // overflowed, never matches
    end
    any_mark = 1'b1;
  endtask

  task automatic decode_beat(input logic [SAMPLE_WIDTH-1:0] s, input logic eom);
    logic dark;
    if (eom) begin
      flush_symbol();
      clear_decoder();
      return;
    end
    dark = s > thr_q;
    if (!dark) begin
      if (have_sample && was_dark) begin
        // tie goes to dash
        add_element(!(gap_between(int'(dot_q), int'(dark_run)) <
                      gap_between(int'(dash_q), int'(dark_run))));
        dark_run = '0;
        light_run = RUN_WIDTH'(1);
      end else if (light_run != RUN_MAX) begin
        light_run++;
      end
    end else begin
      if (have_sample && !was_dark) begin
        if (any_mark && !(gap_between(int'(sgap_q), int'(light_run)) <
                          gap_between(int'(lgap_q), int'(light_run))))
          flush_symbol();
        light_run = '0;
        dark_run = RUN_WIDTH'(1);
      end else if (dark_run != RUN_MAX) begin
        dark_run++;
      end
    end
    was_dark = dark;
    have_sample = 1'b1;
  endtask

  // result side: check each beat, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_chars.size() == 0) begin
          report_err($sformatf("char %0d with nothing expected", out_ch.char_code));
        end else begin
          want_code = pending_chars.pop_front();
          if (out_ch.char_code !== want_code)
            report_err($sformatf("char_code %0d, expected %0d", out_ch.char_code, want_code));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_beat(input logic [SAMPLE_WIDTH-1:0] s, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    decode_beat(s, eom);
    beats_sent++;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] level(input bit dark);
    if (dark) begin
      if (thr_q == '1) return '1;
      if ($urandom_range(3) == 0) return SAMPLE_WIDTH'(thr_q + 1);
      return SAMPLE_WIDTH'($urandom_range(1023, thr_q + 1));
    end
    if ($urandom_range(3) == 0) return ($urandom_range(1)) ? thr_q : '0;
    return SAMPLE_WIDTH'($urandom_range(thr_q, 0));
  endfunction

  task automatic send_run(input bit dark, input int len);
    if (len < 1) len = 1;
    repeat (len) send_beat(level(dark), 1'b0);
  endtask

  function automatic int jitter(input int w);
    if (w == 0) return 0;
    return int'($urandom_range(2 * w)) - w;
  endfunction

  // one symbol at the calibrated lengths, each run jittered by up to wobble, closed by a long gap
  task automatic send_elements(input int n, input logic [8:0] bits, input int wobble);
    for (int k = 0; k < n; k++) begin
      send_run(1'b1, int'(bits[k] ? dash_q : dot_q) + jitter(wobble));
      send_run(1'b0, int'((k == n - 1) ? lgap_q : sgap_q) + jitter(wobble));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_DARK_THRESHOLD:   thr_q = value[THRESH_WIDTH-1:0];
      REG_DOT_LENGTH:       dot_q = value;
      REG_DASH_LENGTH:      dash_q = value;
      REG_SHORT_GAP_LENGTH: sgap_q = value;
      REG_LONG_GAP_LENGTH:  lgap_q = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] thr_word, input logic [15:0] dot,
                           input logic [15:0] dash, input logic [15:0] sgap,
                           input logic [15:0] lgap);
    wait_idle();
    write_reg(REG_DARK_THRESHOLD, thr_word);
    write_reg(REG_DOT_LENGTH, dot);
    write_reg(REG_DASH_LENGTH, dash);
    write_reg(REG_SHORT_GAP_LENGTH, sgap);
    write_reg(REG_LONG_GAP_LENGTH, lgap);
    cfg.valid <= 1'b0;
  endtask

  // reset defaults: threshold 512, dot 1, dash 2, gaps 1 and 2
  task automatic test_default_decode();
    send_beat(10'd0, 1'b0);     // first sample, no edge
    send_beat(10'd512, 1'b0);   // equal to threshold is light
    send_beat(10'd300, 1'b0);
    send_beat(10'd513, 1'b0);   // long gap before any mark: ignored
    send_beat(10'd0, 1'b0);     // dot
    send_beat(10'd1023, 1'b0);
    send_beat(10'd700, 1'b0);
    send_beat(10'd512, 1'b0);   // dash
    send_beat(10'd0, 1'b0);
    send_beat(10'd513, 1'b0);   // long gap ends A
    send_beat(10'd5, 1'b0);     // dot
    send_beat(10'd1023, 1'b1);  // flush E
    send_beat(10'd0, 1'b1);     // empty pattern
    send_beat(10'd1023, 1'b0);
    send_beat(10'd0, 1'b0);     // dot
    send_beat(10'd600, 1'b0);
    send_beat(10'd600, 1'b0);
    send_beat(10'd600, 1'b0);
    send_beat(10'd777, 1'b1);   // open dark run dropped, E flushed
  endtask

  task automatic test_pattern_limits();
    configure(16'd512, 16'd1, 16'd3, 16'd1, 16'd3);
    send_elements(8, 9'h000, 0);   // overflow: nothing
    send_beat(10'd0, 1'b1);
    send_elements(7, 9'h000, 0);   // space
    send_beat(10'd0, 1'b1);
    send_elements(6, 9'h000, 0);   // no entry
    send_beat(10'd0, 1'b1);
    send_elements(5, 9'h00A, 0);   // no entry
    send_beat(10'd0, 1'b1);
    send_elements(5, 9'h01F, 0);   // zero, ended by next mark
    send_beat(10'd700, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd0, 1'b1);
    // ties: mark of 2 is a dash, gap of 2 is long
    send_beat(10'd900, 1'b0);
    send_beat(10'd900, 1'b0);
    send_beat(10'd100, 1'b0);
    send_beat(10'd100, 1'b0);
    send_beat(10'd900, 1'b0);
    send_beat(10'd100, 1'b0);
    send_beat(10'd0, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    configure(16'hFC00, 16'd1, 16'd2, 16'd1, 16'd2);   // threshold 0, junk above it
    send_beat(10'd0, 1'b1);
    send_beat(10'd0, 1'b0);
    send_beat(10'd1, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd1023, 1'b0);
    send_beat(10'd2, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd1, 1'b0);
    send_beat(10'd0, 1'b1);
    configure(16'h03FF, 16'd1, 16'd2, 16'd1, 16'd2);   // nothing is dark
    send_beat(10'd1023, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd1023, 1'b0);
    send_beat(10'd512, 1'b0);
    send_beat(10'd1023, 1'b1);
  endtask

  task automatic test_equal_lengths();
    configure(16'd512, 16'd3, 16'd3, 16'd2, 16'd2);
    send_beat(10'd0, 1'b1);
    send_beat(10'd513, 1'b0);
    send_beat(10'd0, 1'b0);
    repeat (4) send_beat(10'd600, 1'b0);
    send_beat(10'd0, 1'b0);
    send_beat(10'd0, 1'b1);
    configure(16'd512, 16'd0, 16'd0, 16'd0, 16'd0);
    send_elements(3, 9'h000, 0);
    send_beat(10'd1023, 1'b0);
    send_beat(10'd0, 1'b1);
  endtask

  task automatic random_traffic(input int beats);
    int first_beat, r, n;
    logic [8:0] bits;
    first_beat = beats_sent;
    while (beats_sent - first_beat < beats) begin
      r = $urandom_range(99);
      if (r < 70) begin
        split_entry(morse_tab[$urandom_range(36)], n, bits);
        send_elements(n, bits, 1);
      end else if (r < 80) begin
        n = $urandom_range(9, 1);
        bits = 9'($urandom);
        send_elements(n, bits, 1);
      end else if (r < 95) begin
        send_beat(SAMPLE_WIDTH'($urandom), 1'b0);
      end else begin
        send_beat(SAMPLE_WIDTH'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_random_phase(input int src_pct, input int snk_pct);
    logic [9:0] thr;
    int dot, sg;
    thr = 10'($urandom_range(900, 100));
    dot = $urandom_range(4, 1);
    sg = $urandom_range(4, 1);
    configure({6'($urandom), thr}, 16'(dot), 16'(dot + $urandom_range(2 * dot + 2, 1)),
              16'(sg), 16'(sg + $urandom_range(2 * sg + 2, 1)));
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    random_traffic(80);
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.end_of_message <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_DARK_THRESHOLD;
    cfg.data <= '0;
    thr_q = 10'd512;
    dot_q = 16'd1;
    dash_q = 16'd2;
    sgap_q = 16'd1;
    lgap_q = 16'd2;
    clear_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_default_decode();
    test_pattern_limits();
    test_threshold_extremes();
    test_equal_lengths();
    test_random_phase(0, 0);
    test_random_phase(64, 0);
    test_random_phase(0, 64);
    test_random_phase(36, 36);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_adaptive_morse_light_decoder: PASS");
    end else begin
      $display("tb_adaptive_morse_light_decoder: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t ns: timeout, %0d chars outstanding", $time, pending_chars.size());
    $display("tb_adaptive_morse_light_decoder: FAIL");
    $finish;
  end

endmodule
